// ===== rtl/som_pkg.sv =====
// Shared types and constants for the substring occurrence matcher.
package som_pkg;

   localparam int CHAR_BITS        = 8;
   localparam int MATCH_START_BITS = 32;

   typedef enum logic {
      KIND_PATTERN = 1'b0,
      KIND_TEXT    = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic                        valid;
      logic [MATCH_START_BITS-1:0] start;
   } match_result_type;

endpackage

// ===== rtl/som_match_core.sv =====
// Pattern cells, partial-match vector and text position tracking.
module som_match_core #(
   parameter int PAT_MAX  = 64,
   parameter int POS_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  som_pkg::item_kind_type        kind,
   input  logic [som_pkg::CHAR_BITS-1:0] char_code,
   input  logic                          start_new,
   output som_pkg::match_result_type     result
);
   import som_pkg::*;

   localparam int LEN_BITS  = $clog2(PAT_MAX + 1);
   localparam int IDX_BITS  = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
   localparam int DIFF_BITS = (POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS;

   logic [CHAR_BITS-1:0] pat_ff [PAT_MAX];
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic                 ovf_ff, ovf_in;
   logic [PAT_MAX-1:0]   part_ff, part_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;

   logic [LEN_BITS-1:0]  len_base;
   logic                 ovf_base;
   logic                 pat_write;
   logic [PAT_MAX-1:0]   part_prev;
   logic [PAT_MAX-1:0]   part_new;
   logic [POS_BITS-1:0]  here;
   logic [LEN_BITS-1:0]  len_m1;
   logic [DIFF_BITS-1:0] start_diff;
   logic [POS_BITS-1:0]  start_pos;
   logic                 hit;

   assign len_base  = start_new ? '0 : len_ff;
   assign ovf_base  = start_new ? 1'b0 : ovf_ff;
   assign pat_write = accept && (kind == KIND_PATTERN)
                      && (len_base < LEN_BITS'(PAT_MAX));

   assign part_prev = start_new ? '0 : part_ff;
   assign here      = start_new ? '0 : pos_ff;

   // bit j: the last j+1 text bytes equal the first j+1 pattern bytes
   always_comb begin
      for (int j = 0; j < PAT_MAX; j++) begin
         if (j == 0) begin
            part_new[j] = (char_code == pat_ff[j]);
         end else begin
            part_new[j] = part_prev[j-1] && (char_code == pat_ff[j]);
         end
      end
   end

   assign len_m1     = len_ff - LEN_BITS'(1);
   assign hit        = !ovf_ff && (len_ff != '0) && part_new[len_m1[IDX_BITS-1:0]];
   assign start_diff = DIFF_BITS'(here) - DIFF_BITS'(len_ff) + DIFF_BITS'(1);
   assign start_pos  = start_diff[POS_BITS-1:0];

   always_comb begin
      len_in  = len_ff;
      ovf_in  = ovf_ff;
      part_in = part_ff;
      pos_in  = pos_ff;
      result.valid = 1'b0;
      result.start = MATCH_START_BITS'(start_pos);
      if (accept) begin
         unique case (kind)
            KIND_PATTERN: begin
               part_in = '0;
               pos_in  = '0;
               if (len_base < LEN_BITS'(PAT_MAX)) begin
                  len_in = len_base + LEN_BITS'(1);
                  ovf_in = ovf_base;
               end else begin
                  len_in = len_base;
                  ovf_in = 1'b1;
               end
            end
            KIND_TEXT: begin
               part_in      = part_new;
               pos_in       = here + POS_BITS'(1);
               result.valid = hit;
            end
            default: begin
               part_in = part_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
         part_ff <= '0;
         pos_ff  <= '0;
      end else begin
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
         part_ff <= part_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pat_write) begin
         pat_ff[len_base[IDX_BITS-1:0]] <= char_code;
      end
   end

endmodule

// ===== rtl/som_out_buffer.sv =====
// Result register with a skid stage toward the response channel.
module som_out_buffer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  som_pkg::match_result_type            result,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [som_pkg::MATCH_START_BITS-1:0] rsp_match_start,
   output logic                                 full
);
   import som_pkg::*;

   logic                        out_valid_ff, out_valid_in;
   logic [MATCH_START_BITS-1:0] out_start_ff, out_start_in;
   logic                        skid_valid_ff, skid_valid_in;
   logic [MATCH_START_BITS-1:0] skid_start_ff, skid_start_in;
   logic                        out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_start_in  = out_start_ff;
      skid_valid_in = skid_valid_ff;
      skid_start_in = skid_start_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_start_in  = skid_start_ff;
            skid_valid_in = result.valid;
            skid_start_in = result.start;
         end else begin
            out_valid_in = result.valid;
            out_start_in = result.start;
         end
      end else if (result.valid) begin
         skid_valid_in = 1'b1;
         skid_start_in = result.start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_start_ff  <= out_start_in;
      skid_start_ff <= skid_start_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_match_start = out_start_ff;
   assign full            = skid_valid_ff;

endmodule

// ===== rtl/substring_occurrence_matcher_top.sv =====
// Top level of the substring occurrence matcher.
//
// Request words carry a pattern byte (req_type = 0) or a text byte
// (req_type = 1); req_start_new begins a new pattern or a new text.
// Pattern bytes load up to PAT_MAX bytes and restart the text. Each text
// byte updates a vector of parallel byte comparators, one per pattern
// cell; when the whole pattern ends on that byte, one response word gives
// the text index where the occurrence begins. Overlapping occurrences all
// appear, in order.
// Throughput: one request word per cycle while req_stall is low. Each
// response is registered in the result register, or first in the skid
// entry, before it drives rsp_valid.
// A result register plus one skid entry sit on the response side; while
// the receiver holds rsp_stall the block keeps taking words until the
// skid entry fills, then raises req_stall.
// Reset (synchronous) empties the pattern, the text and both result
// stages; pattern cell contents are kept but unused until rewritten.
module substring_occurrence_matcher_top #(
   parameter int PAT_MAX  = 64,
   parameter int POS_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [som_pkg::CHAR_BITS-1:0]        req_char_code,
   input  logic                                 req_start_new,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [som_pkg::MATCH_START_BITS-1:0] rsp_match_start
);
   import som_pkg::*;

   logic             accept;
   logic             buf_full;
   item_kind_type    kind;
   match_result_type result;

   assign accept    = req_valid && !buf_full;
   assign req_stall = buf_full;
   assign kind      = item_kind_type'(req_type);

   som_match_core #(
      .PAT_MAX  (PAT_MAX),
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (kind),
      .char_code (req_char_code),
      .start_new (req_start_new),
      .result    (result)
   );

   som_out_buffer u_out (
      .clock           (clock),
      .reset           (reset),
      .result          (result),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_match_start (rsp_match_start),
      .full            (buf_full)
   );

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry held while result register empty");

   a_pattern_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && kind == KIND_PATTERN && !rsp_valid) |=> !rsp_valid)
      else $error("pattern word produced a result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall raised without a held result");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the substring occurrence matcher: directed cases, then random streams.
module testbench;
   import som_pkg::*;

   localparam int PAT_MAX     = 64;
   localparam int POS_BITS    = 32;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 8;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_type = KIND_PATTERN;
   logic [CHAR_BITS-1:0]        req_char_code = '0;
   logic                        req_start_new = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [MATCH_START_BITS-1:0] rsp_match_start;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   int words_sent = 0;
   int pattern_words = 0;
   int text_words = 0;
   int match_words = 0;

   // predicted matcher state
   logic [CHAR_BITS-1:0]        pat_bytes [PAT_MAX];
   int unsigned                 pat_len = 0;
   bit                          pat_over = 1'b0;
   logic [CHAR_BITS-1:0]        text_win [PAT_MAX];
   int unsigned                 win_head = 0;
   int unsigned                 win_fill = 0;
   logic [POS_BITS-1:0]         text_pos = '0;
   logic [MATCH_START_BITS-1:0] expected_starts [$];
   logic [MATCH_START_BITS-1:0] oldest_start;

   // stimulus scratch
   logic [CHAR_BITS-1:0]        cur_pattern [$];
   logic [CHAR_BITS-1:0]        cur_alphabet [2];
   bit                          text_fresh_pending = 1'b0;

   substring_occurrence_matcher_top #(
      .PAT_MAX (PAT_MAX),
      .POS_BITS(POS_BITS)
   ) dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic void restart_scan();
      win_head = 0;
      win_fill = 0;
      text_pos = '0;
   endfunction

   function automatic void predict_match(input item_kind_type kind,
                                         input logic [CHAR_BITS-1:0] ch, input logic fresh);
      int unsigned         base;
      logic [POS_BITS-1:0] here;
      bit                  hit;
      if (kind == KIND_PATTERN) begin
         if (fresh) begin
            pat_len = 0;
            pat_over = 1'b0;
         end
         restart_scan();
         if (pat_len < PAT_MAX) begin
            pat_bytes[pat_len] = ch;
            pat_len++;
         end else begin
            pat_over = 1'b1;
         end
      end else begin
         if (fresh)
            restart_scan();
         text_win[win_head] = ch;
         win_head = (win_head + 1) % PAT_MAX;
         if (win_fill < PAT_MAX)
            win_fill++;
         here = text_pos;
         text_pos = text_pos + 1'b1;
         hit = !pat_over && pat_len != 0 && win_fill >= pat_len;
         base = win_head + PAT_MAX - pat_len;
         for (int i = 0; i < pat_len && hit; i++) begin
            if (text_win[(base + i) % PAT_MAX] != pat_bytes[i])
               hit = 1'b0;
         end
         if (hit)
            expected_starts = {expected_starts,
                               MATCH_START_BITS'(here - POS_BITS'(pat_len) + 1'b1)};
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            match_words++;
            if (expected_starts.size() == 0) begin
               $error("match_start: no word expected, got %0d", rsp_match_start);
               fail_count++;
            end else begin
               oldest_start = expected_starts.pop_front();
               if (rsp_match_start !== oldest_start) begin
                  $error("match_start: expected %0d, got %0d", oldest_start, rsp_match_start);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == KIND_PATTERN)
               pattern_words++;
            else
               text_words++;
            predict_match(item_kind_type'(req_type), req_char_code, req_start_new);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $error("timeout: %0d cycles without a handshake", idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_word(input item_kind_type kind, input logic [CHAR_BITS-1:0] ch,
                            input logic fresh);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_char_code <= ch;
      req_start_new <= fresh;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_sent++;
   endtask

   task automatic send_text(input logic [CHAR_BITS-1:0] ch);
      send_word(KIND_TEXT, ch, text_fresh_pending);
      text_fresh_pending = 1'b0;
   endtask

   task automatic wait_for_drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_starts.size() != 0 && waited < IDLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CHAR_BITS-1:0] pick_symbol();
      return cur_alphabet[$urandom_range(1)];
   endfunction

   function automatic void build_pattern(input int len);
      cur_alphabet[0] = CHAR_BITS'($urandom);
      cur_alphabet[1] = CHAR_BITS'($urandom);
      cur_pattern.delete();
      repeat (len) cur_pattern = {cur_pattern, pick_symbol()};
   endfunction

   task automatic load_pattern();
      foreach (cur_pattern[i])
         send_word(KIND_PATTERN, cur_pattern[i], i == 0);
   endtask

   task automatic send_pattern_copy();
      foreach (cur_pattern[i]) begin
         if (i < PAT_MAX)
            send_text(cur_pattern[i]);
      end
   endtask

   task automatic test_empty_pattern();
      send_word(KIND_TEXT, 8'h00, 1'b1);
      send_word(KIND_TEXT, 8'hFF, 1'b0);
      send_word(KIND_TEXT, 8'h00, 1'b0);
   endtask

   task automatic test_overlapping_matches();
      send_word(KIND_PATTERN, 8'hFF, 1'b1);
      send_word(KIND_PATTERN, 8'hFF, 1'b0);
      send_word(KIND_TEXT, 8'hFF, 1'b1);
      send_word(KIND_TEXT, 8'hFF, 1'b0);
      send_word(KIND_TEXT, 8'hFF, 1'b0);
   endtask

   task automatic test_pattern_restarts_text();
      send_word(KIND_PATTERN, 8'hA5, 1'b1);
      send_word(KIND_TEXT, 8'h5A, 1'b1);
      send_word(KIND_TEXT, 8'hA5, 1'b0);
      // append without start: pattern grows and text restarts at index 0
      send_word(KIND_PATTERN, 8'h5A, 1'b0);
      send_word(KIND_TEXT, 8'hA5, 1'b0);
      send_word(KIND_TEXT, 8'h5A, 1'b0);
   endtask

   task automatic test_new_text();
      send_word(KIND_TEXT, 8'hA5, 1'b0);
      send_word(KIND_TEXT, 8'h00, 1'b1);
      send_word(KIND_TEXT, 8'hA5, 1'b0);
      send_word(KIND_TEXT, 8'h5A, 1'b0);
   endtask

   task automatic test_new_pattern();
      send_word(KIND_PATTERN, 8'h3C, 1'b1);
      send_word(KIND_TEXT, 8'h3C, 1'b1);
      send_word(KIND_TEXT, 8'hC3, 1'b0);
      send_word(KIND_TEXT, 8'h3C, 1'b0);
   endtask

   // full-length pattern, then one byte past the store (overflow, no matches)
   task automatic test_long_patterns();
      int lengths [2];
      lengths[0] = PAT_MAX;
      lengths[1] = PAT_MAX + 1;
      foreach (lengths[k]) begin
         build_pattern(lengths[k]);
         load_pattern();
         text_fresh_pending = 1'b1;
         send_text(pick_symbol());
         send_text(pick_symbol());
         send_pattern_copy();
         send_text(pick_symbol());
      end
      wait_for_drain();
   endtask

   task automatic play_sequence();
      build_pattern($urandom_range(1, 6));
      load_pattern();
      text_fresh_pending = ($urandom_range(3) != 0);
      repeat ($urandom_range(2, 10)) begin
         if ($urandom_range(2) == 0)
            send_pattern_copy();
         else
            repeat ($urandom_range(1, 4)) send_text(pick_symbol());
      end
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall, input int items);
      int stop_at;
      int pick;
      stop_at = words_sent + items;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            play_sequence();
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 6)) begin
               send_word(item_kind_type'($urandom_range(1)), CHAR_BITS'($urandom),
                         1'($urandom));
            end
         end else if (pick < 93) begin
            // text restarted mid-stream
            text_fresh_pending = 1'b1;
            repeat ($urandom_range(1, 8)) send_text(pick_symbol());
         end else begin
            // stray pattern byte appended, then more text
            send_word(KIND_PATTERN, pick_symbol(), 1'b0);
            repeat ($urandom_range(1, 8)) send_text(pick_symbol());
         end
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_pattern();
      test_overlapping_matches();
      test_pattern_restarts_text();
      test_new_text();
      test_new_pattern();
      wait_for_drain();
      test_long_patterns();
      run_random_phase(0, 0, 170);
      run_random_phase(51, 0, 170);
      run_random_phase(0, 51, 170);
      run_random_phase(30, 30, 170);
      if (expected_starts.size() != 0) begin
         $error("match_start: %0d expected words never arrived", expected_starts.size());
         fail_count++;
      end
      $display("covered %0d pattern and %0d text words, %0d match words checked,",
               pattern_words, text_words, match_words);
      $display("  incl. empty, full-length and overflowed patterns under four pacing mixes");
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
